// ===== hdl/sensor_reply_checker_to_loop_dac_unit_assert.svh =====
// Assertion macros for the sensor reply checker.
// Used by the top level; no other dependencies.
`ifndef SENSOR_REPLY_CHECKER_TO_LOOP_DAC_UNIT_ASSERT_SVH
`define SENSOR_REPLY_CHECKER_TO_LOOP_DAC_UNIT_ASSERT_SVH

// same-cycle implication, reset masks the check
`define SRCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srcd: same-cycle check failed");

// next-cycle implication, reset masks the check
`define SRCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srcd: next-cycle check failed");

`endif

// ===== hdl/srcd_pkg.sv =====
// Shared types and constants for the sensor reply checker.
// No dependencies; used by every module of the block.
`default_nettype none

package srcd_pkg;

    // frame layout
    localparam int FRAME_BYTES = 10;
    localparam int LAST_POS    = FRAME_BYTES - 1;
    localparam int CSUM_BYTES  = FRAME_BYTES - 2;
    localparam int POS_W       = 4;

    localparam logic [7:0] HDR_BYTE  = 8'h55;
    localparam logic [7:0] TAIL_BYTE = 8'hAA;

    // DAC mapping
    localparam int CONC_W = 16;
    localparam int CODE_W = 12;
    localparam logic [CODE_W-1:0] CODE_MIN  = 12'd729;
    localparam logic [CODE_W-1:0] CODE_MAX  = 12'd3649;
    localparam logic [CODE_W-1:0] CODE_SPAN = 12'd2920;
    localparam logic [CONC_W-1:0] CONC_BAD  = 16'hFFFF;

    // divider sizes: concentration times span, over the range register
    localparam int DIVIDEND_W = CONC_W + CODE_W;
    localparam int DIVISOR_W  = 32;

    // action codes
    localparam logic [1:0] ACT_BYTE    = 2'd0;
    localparam logic [1:0] ACT_TIMEOUT = 2'd1;
    localparam logic [1:0] ACT_FAULT   = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    // response byte codes
    localparam logic [7:0] RESP_OK      = 8'h01;
    localparam logic [7:0] RESP_EXEC    = 8'h02;
    localparam logic [7:0] RESP_CMD_ERR = 8'h03;
    localparam logic [7:0] RESP_NO_ZERO = 8'h04;

    // sensor status byte codes
    localparam logic [7:0] SNS_UNCAL      = 8'h00;
    localparam logic [7:0] SNS_OK         = 8'h01;
    localparam logic [7:0] SNS_ZERO_SHIFT = 8'h02;
    localparam logic [7:0] SNS_CALIB      = 8'h03;
    localparam logic [7:0] SNS_FAULT      = 8'h04;

    // result status codes
    localparam logic [3:0] STS_OK         = 4'd0;
    localparam logic [3:0] STS_TIMEOUT    = 4'd1;
    localparam logic [3:0] STS_RX_FAULT   = 4'd2;
    localparam logic [3:0] STS_FRAMING    = 4'd3;
    localparam logic [3:0] STS_CMD        = 4'd4;
    localparam logic [3:0] STS_EXEC       = 4'd5;
    localparam logic [3:0] STS_NO_ZERO    = 4'd6;
    localparam logic [3:0] STS_BAD_RESP   = 4'd7;
    localparam logic [3:0] STS_CHECKSUM   = 4'd8;
    localparam logic [3:0] STS_UNCAL      = 4'd9;
    localparam logic [3:0] STS_ZERO_SHIFT = 4'd10;
    localparam logic [3:0] STS_CALIB      = 4'd11;
    localparam logic [3:0] STS_FAULT      = 4'd12;
    localparam logic [3:0] STS_BAD_STATUS = 4'd13;
    localparam logic [3:0] STS_BAD_VALUE  = 4'd14;
    localparam logic [3:0] STS_NOT_READY  = 4'd15;

    // configuration register indexes
    localparam logic [2:0] REG_RANGE     = 3'd0;
    localparam logic [2:0] REG_ZERO      = 3'd1;
    localparam logic [2:0] REG_COMMAND   = 3'd2;
    localparam logic [2:0] REG_RETRIES   = 3'd3;
    localparam logic [2:0] REG_LOST_LIM  = 3'd4;
    localparam logic [2:0] REG_ALARM     = 3'd5;
    localparam logic [2:0] REG_READY     = 3'd6;

    // frame capture result towards the sequencer
    typedef struct packed {
        logic              last;
        logic [3:0]        status;
        logic [CONC_W-1:0] conc;
    } t_frame_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAP,
        S_DIV,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/sensor_reply_checker_to_loop_dac_unit.sv =====
// Sensor reply checker: takes reply bytes or receive events, checks each
// 10-byte frame and maps a good concentration onto a loop DAC code, with
// retry and lost-update accounting and a forced alarm code. A byte that
// does not end a frame does not stall the input. An item with a result
// runs through S_FINISH on a failure, through S_MAP and S_FINISH on a
// trivial mapping, or through S_MAP, S_DIV (the 28-step serial divider)
// and S_FINISH for a concentration inside the range. Input stall is high
// while an item is at work and while a result waits for the output register.
// Depends on srcd_pkg, srcd_frame, srcd_div and the assertion macro header.
`default_nettype none

module sensor_reply_checker_to_loop_dac_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input words
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_action,
    input  wire logic [7:0]                    i_rx_byte,
    // result words
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [3:0]                         o_status,
    output logic [srcd_pkg::CONC_W-1:0]        o_concentration,
    output logic [srcd_pkg::CODE_W-1:0]        o_dac_code,
    output logic                               o_dac_update,
    output logic                               o_resend,
    output logic [7:0]                         o_lost_count,
    // configuration writes
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);

    `include "sensor_reply_checker_to_loop_dac_unit_assert.svh"

    // configuration registers
    logic [31:0]                 r_range;
    logic [15:0]                 r_zero;
    logic [7:0]                  r_command;
    logic [2:0]                  r_max_retries;
    logic [7:0]                  r_lost_limit;
    logic [srcd_pkg::CODE_W-1:0] r_alarm;
    logic                        r_ready;

    // sequencer state
    srcd_pkg::t_state            r_state, n_state;
    logic                        r_nready, n_nready;
    logic [3:0]                  r_status, n_status;
    logic [srcd_pkg::CONC_W-1:0] r_conc, n_conc;
    logic [srcd_pkg::CODE_W-1:0] r_code, n_code;
    logic [2:0]                  r_retry, n_retry;
    logic [7:0]                  r_lost, n_lost;

    // output register
    logic                        r_out_valid, n_out_valid;
    logic [3:0]                  r_o_status, n_o_status;
    logic [srcd_pkg::CONC_W-1:0] r_o_conc, n_o_conc;
    logic [srcd_pkg::CODE_W-1:0] r_o_code, n_o_code;
    logic                        r_o_update, n_o_update;
    logic                        r_o_resend, n_o_resend;

    logic                        w_in_acc;
    logic                        w_take;
    logic                        w_div_start;
    logic                        w_div_done;
    logic [srcd_pkg::DIVIDEND_W-1:0] w_quotient;
    logic [srcd_pkg::DIVIDEND_W-1:0] w_product;
    logic [2:0]                  w_retry_inc;
    logic [7:0]                  w_lost_inc;
    srcd_pkg::t_frame_res        w_frame;

    assign w_in_acc = i_in_valid && r_state == srcd_pkg::S_IDLE;
    assign w_take   = w_in_acc && r_ready && i_action != srcd_pkg::ACT_NONE;

    assign w_product   = srcd_pkg::DIVIDEND_W'(r_conc) * srcd_pkg::DIVIDEND_W'(srcd_pkg::CODE_SPAN);
    assign w_retry_inc = r_retry + 3'd1;
    assign w_lost_inc  = (r_lost == 8'hFF) ? r_lost : r_lost + 8'd1;

    srcd_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_action  (i_action),
        .i_rx_byte (i_rx_byte),
        .i_command (r_command),
        .o_res     (w_frame)
    );

    srcd_div #(
        .DIVIDEND_W (srcd_pkg::DIVIDEND_W),
        .DIVISOR_W  (srcd_pkg::DIVISOR_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_product),
        .i_divisor  (r_range),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // configuration write port, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range       <= '0;
            r_zero        <= '0;
            r_command     <= 8'd3;
            r_max_retries <= 3'd3;
            r_lost_limit  <= 8'd3;
            r_alarm       <= 12'd4095;
            r_ready       <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                srcd_pkg::REG_RANGE:    r_range       <= i_cfg_data;
                srcd_pkg::REG_ZERO:     r_zero        <= i_cfg_data[15:0];
                srcd_pkg::REG_COMMAND:  r_command     <= i_cfg_data[7:0];
                srcd_pkg::REG_RETRIES:  r_max_retries <= i_cfg_data[2:0];
                srcd_pkg::REG_LOST_LIM: r_lost_limit  <= i_cfg_data[7:0];
                srcd_pkg::REG_ALARM:    r_alarm       <= i_cfg_data[11:0];
                srcd_pkg::REG_READY:    r_ready       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // state and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srcd_pkg::S_IDLE;
            r_retry     <= '0;
            r_lost      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_retry     <= n_retry;
            r_lost      <= n_lost;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nready   <= n_nready;
        r_status   <= n_status;
        r_conc     <= n_conc;
        r_code     <= n_code;
        r_o_status <= n_o_status;
        r_o_conc   <= n_o_conc;
        r_o_code   <= n_o_code;
        r_o_update <= n_o_update;
        r_o_resend <= n_o_resend;
    end

    // sequencer: next state and result assembly
    always_comb begin
        n_state     = r_state;
        n_nready    = r_nready;
        n_status    = r_status;
        n_conc      = r_conc;
        n_code      = r_code;
        n_retry     = r_retry;
        n_lost      = r_lost;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_status  = r_o_status;
        n_o_conc    = r_o_conc;
        n_o_code    = r_o_code;
        n_o_update  = r_o_update;
        n_o_resend  = r_o_resend;
        w_div_start = 1'b0;

        unique case (r_state)
            srcd_pkg::S_IDLE: begin
                if (w_in_acc && i_action != srcd_pkg::ACT_NONE) begin
                    n_nready = !r_ready;
                    if (!r_ready) begin
                        n_state = srcd_pkg::S_FINISH;
                    end else if (i_action == srcd_pkg::ACT_TIMEOUT) begin
                        n_status = srcd_pkg::STS_TIMEOUT;
                        n_state  = srcd_pkg::S_FINISH;
                    end else if (i_action == srcd_pkg::ACT_FAULT) begin
                        n_status = srcd_pkg::STS_RX_FAULT;
                        n_state  = srcd_pkg::S_FINISH;
                    end else if (w_frame.last) begin
                        n_status = w_frame.status;
                        n_conc   = w_frame.conc;
                        n_state  = (w_frame.status == srcd_pkg::STS_OK) ?
                                   srcd_pkg::S_MAP : srcd_pkg::S_FINISH;
                    end
                end
            end
            srcd_pkg::S_MAP: begin
                // end points without division
                if (r_range == '0 || r_conc <= r_zero) begin
                    n_code  = srcd_pkg::CODE_MIN;
                    n_state = srcd_pkg::S_FINISH;
                end else if (32'(r_conc) >= r_range) begin
                    n_code  = srcd_pkg::CODE_MAX;
                    n_state = srcd_pkg::S_FINISH;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = srcd_pkg::S_DIV;
                end
            end
            srcd_pkg::S_DIV: begin
                // quotient stays below the span, so no clamp is needed
                if (w_div_done) begin
                    n_code  = srcd_pkg::CODE_MIN + w_quotient[srcd_pkg::CODE_W-1:0];
                    n_state = srcd_pkg::S_FINISH;
                end
            end
            srcd_pkg::S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_state     = srcd_pkg::S_IDLE;
                    n_o_conc    = '0;
                    n_o_code    = '0;
                    n_o_update  = 1'b0;
                    n_o_resend  = 1'b0;
                    if (r_nready) begin
                        n_o_status = srcd_pkg::STS_NOT_READY;
                    end else if (r_status == srcd_pkg::STS_OK) begin
                        n_o_status = srcd_pkg::STS_OK;
                        n_o_conc   = r_conc;
                        n_o_code   = r_code;
                        n_o_update = 1'b1;
                        n_retry    = '0;
                        n_lost     = '0;
                    end else begin
                        n_o_status = r_status;
                        if (w_retry_inc < r_max_retries) begin
                            n_retry    = w_retry_inc;
                            n_o_resend = 1'b1;
                        end else begin
                            n_retry = '0;
                            n_lost  = w_lost_inc;
                            if (w_lost_inc >= r_lost_limit) begin
                                n_o_code   = r_alarm;
                                n_o_update = 1'b1;
                            end
                        end
                    end
                end
            end
            default: n_state = srcd_pkg::S_IDLE;
        endcase
    end

    assign o_in_stall      = r_state != srcd_pkg::S_IDLE;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_concentration = r_o_conc;
    assign o_dac_code      = r_o_code;
    assign o_dac_update    = r_o_update;
    assign o_resend        = r_o_resend;
    assign o_lost_count    = r_lost;

    // checks on the block's own logic
    `SRCD_ASSERT_IMPL(a_fail_no_conc, i_clk, i_rst_n,
        o_out_valid && o_status != srcd_pkg::STS_OK, o_concentration == '0)
    `SRCD_ASSERT_IMPL(a_resend_no_update, i_clk, i_rst_n,
        o_out_valid && o_resend, !o_dac_update && o_status != srcd_pkg::STS_OK)
    `SRCD_ASSERT_IMPL(a_ok_code_span, i_clk, i_rst_n,
        o_out_valid && o_status == srcd_pkg::STS_OK,
        o_dac_update && o_dac_code >= srcd_pkg::CODE_MIN && o_dac_code <= srcd_pkg::CODE_MAX)
    `SRCD_ASSERT_NEXT(a_div_to_finish, i_clk, i_rst_n,
        r_state == srcd_pkg::S_DIV && w_div_done, r_state == srcd_pkg::S_FINISH)

endmodule

`default_nettype wire

// ===== hdl/srcd_frame.sv =====
// Frame capture and check: byte store, running sum, priority checks.
// Depends on srcd_pkg.
`default_nettype none

module srcd_frame (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_take,
    input  wire logic [1:0]            i_action,
    input  wire logic [7:0]            i_rx_byte,
    input  wire logic [7:0]            i_command,
    output srcd_pkg::t_frame_res       o_res
);

    localparam logic [srcd_pkg::POS_W-1:0] LAST = srcd_pkg::POS_W'(srcd_pkg::LAST_POS);
    localparam logic [srcd_pkg::POS_W-1:0] CSUM = srcd_pkg::POS_W'(srcd_pkg::CSUM_BYTES);

    logic [srcd_pkg::POS_W-1:0] r_pos;
    logic [7:0]                 r_sum;
    logic [7:0]                 r_store [srcd_pkg::LAST_POS];

    logic [srcd_pkg::POS_W-1:0] w_pos;
    logic [7:0]                 w_csum;
    logic [3:0]                 w_status;
    logic [srcd_pkg::CONC_W-1:0] w_conc;

    // out-of-range position wraps to the start of a frame
    assign w_pos  = (r_pos > LAST) ? '0 : r_pos;
    assign w_csum = 8'(~r_sum + 8'd1);
    assign w_conc = {r_store[3], r_store[4]};

    // position and running checksum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
        end else if (i_take) begin
            if (i_action == srcd_pkg::ACT_BYTE && w_pos != LAST) begin
                r_pos <= w_pos + 1'b1;
                if (w_pos < CSUM) r_sum <= r_sum + i_rx_byte;
            end else begin
                r_pos <= '0;
                r_sum <= '0;
            end
        end
    end

    // byte store; last byte is checked straight off the input
    always_ff @(posedge i_clk) begin
        if (i_take && i_action == srcd_pkg::ACT_BYTE && w_pos != LAST) begin
            r_store[w_pos] <= i_rx_byte;
        end
    end

    // checks in priority order
    always_comb begin
        w_status = srcd_pkg::STS_OK;
        if (r_store[0] != srcd_pkg::HDR_BYTE || i_rx_byte != srcd_pkg::TAIL_BYTE) begin
            w_status = srcd_pkg::STS_FRAMING;
        end else if (r_store[1] != i_command) begin
            w_status = srcd_pkg::STS_CMD;
        end else if (r_store[2] == srcd_pkg::RESP_EXEC) begin
            w_status = srcd_pkg::STS_EXEC;
        end else if (r_store[2] == srcd_pkg::RESP_CMD_ERR) begin
            w_status = srcd_pkg::STS_CMD;
        end else if (r_store[2] == srcd_pkg::RESP_NO_ZERO) begin
            w_status = srcd_pkg::STS_NO_ZERO;
        end else if (r_store[2] != srcd_pkg::RESP_OK) begin
            w_status = srcd_pkg::STS_BAD_RESP;
        end else if (r_store[8] != w_csum) begin
            w_status = srcd_pkg::STS_CHECKSUM;
        end else if (r_store[7] == srcd_pkg::SNS_UNCAL) begin
            w_status = srcd_pkg::STS_UNCAL;
        end else if (r_store[7] == srcd_pkg::SNS_ZERO_SHIFT) begin
            w_status = srcd_pkg::STS_ZERO_SHIFT;
        end else if (r_store[7] == srcd_pkg::SNS_CALIB) begin
            w_status = srcd_pkg::STS_CALIB;
        end else if (r_store[7] == srcd_pkg::SNS_FAULT) begin
            w_status = srcd_pkg::STS_FAULT;
        end else if (r_store[7] != srcd_pkg::SNS_OK) begin
            w_status = srcd_pkg::STS_BAD_STATUS;
        end else if (w_conc == srcd_pkg::CONC_BAD) begin
            w_status = srcd_pkg::STS_BAD_VALUE;
        end
    end

    assign o_res.last   = i_take && i_action == srcd_pkg::ACT_BYTE && w_pos == LAST;
    assign o_res.status = w_status;
    assign o_res.conc   = w_conc;

endmodule

`default_nettype wire

// ===== hdl/srcd_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on srcd_pkg for default widths.
`default_nettype none

module srcd_div #(
    parameter int DIVIDEND_W = srcd_pkg::DIVIDEND_W,
    parameter int DIVISOR_W  = srcd_pkg::DIVISOR_W
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [DIVIDEND_W-1:0]      o_quotient
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_dvd;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIVISOR_W:0]    w_trial;
    logic                  w_qbit;

    // one trial subtraction per step
    assign w_trial = {r_rem, r_dvd[DIVIDEND_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_dvs});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && r_cnt == CNT_LAST;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) r_busy <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DIVIDEND_W-2:0], 1'b0};
            r_rem <= w_qbit ? DIVISOR_W'(w_trial - {1'b0, r_dvs}) : DIVISOR_W'(w_trial);
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_qbit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== sim/tb_sensor_reply_checker_to_loop_dac_unit.sv =====
// Testbench for the sensor reply checker: drives reply bytes and receive events,
// predicts each result from its own model of the frame checks, retry and lost
// accounting and DAC mapping, and checks the result words. Needs srcd_pkg and the RTL.
`timescale 1ns / 1ps

module tb_sensor_reply_checker_to_loop_dac_unit;

    // frame kinds used by the stimulus
    localparam int FR_GOOD         = 0;
    localparam int FR_BAD_HDR      = 1;
    localparam int FR_BAD_TAIL     = 2;
    localparam int FR_BAD_CMD      = 3;
    localparam int FR_RESP_EXEC    = 4;
    localparam int FR_RESP_CMD_ERR = 5;
    localparam int FR_RESP_NO_ZERO = 6;
    localparam int FR_RESP_OTHER   = 7;
    localparam int FR_BAD_SUM      = 8;
    localparam int FR_SNS_UNCAL    = 9;
    localparam int FR_SNS_SHIFT    = 10;
    localparam int FR_SNS_CALIB    = 11;
    localparam int FR_SNS_FAULT    = 12;
    localparam int FR_SNS_OTHER    = 13;
    localparam int FR_BAD_VALUE    = 14;
    localparam int FR_CUT_TIMEOUT  = 15;
    localparam int FR_CUT_FAULT    = 16;
    localparam int FR_TIMEOUT      = 17;
    localparam int FR_FAULT        = 18;
    localparam int FR_NOISE        = 19;

    // receiver stall pattern kinds
    localparam int STALL_FREE   = 0;
    localparam int STALL_HOLD   = 1;
    localparam int STALL_CHOPPY = 2;

    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 1000;

    localparam int CONC_W     = srcd_pkg::CONC_W;
    localparam int CODE_W     = srcd_pkg::CODE_W;
    localparam int FR_LEN     = srcd_pkg::FRAME_BYTES;
    localparam int FR_LAST    = srcd_pkg::LAST_POS;
    localparam int FR_CSUM    = srcd_pkg::CSUM_BYTES;

    typedef struct packed {
        logic [1:0] act;
        logic [7:0] rx;
    } t_word;

    typedef struct {
        logic [3:0]        status;
        logic [CONC_W-1:0] conc;
        logic [CODE_W-1:0] code;
        logic              upd;
        logic              resend;
        logic [7:0]        lost;
    } t_reply;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_action = srcd_pkg::ACT_NONE;
    logic [7:0]          i_rx_byte = 8'h00;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [3:0]          o_status;
    logic [CONC_W-1:0]   o_concentration;
    logic [CODE_W-1:0]   o_dac_code;
    logic                o_dac_update;
    logic                o_resend;
    logic [7:0]          o_lost_count;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [2:0]          i_cfg_index = srcd_pkg::REG_RANGE;
    logic [31:0]         i_cfg_data = 32'h0;

    sensor_reply_checker_to_loop_dac_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_concentration (o_concentration),
        .o_dac_code      (o_dac_code),
        .o_dac_update    (o_dac_update),
        .o_resend        (o_resend),
        .o_lost_count    (o_lost_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // register copies, at their reset values
    logic [31:0]       range_reg    = 32'd0;
    logic [15:0]       zero_reg     = 16'd0;
    logic [7:0]        cmd_reg      = 8'd3;
    logic [2:0]        retries_reg  = 3'd3;
    logic [7:0]        lost_lim_reg = 8'd3;
    logic [CODE_W-1:0] alarm_reg    = 12'd4095;
    logic              ready_reg    = 1'b0;

    // checker state
    logic [srcd_pkg::POS_W-1:0] byte_pos = '0;
    logic [7:0]        sum_acc   = 8'd0;
    logic [7:0]        frame_img [FR_LEN];
    logic [2:0]        retry_cnt = 3'd0;
    logic [7:0]        lost_cnt  = 8'd0;

    t_word  words_to_send[$];
    t_reply replies_due[$];

    bit word_taken = 1'b0;
    int burst_left = 0;
    int gap_left   = 0;
    int stall_kind = STALL_FREE;
    int stall_left = 0;

    int faults         = 0;
    int words_queued   = 0;
    int words_accepted = 0;
    int results_seen   = 0;
    int reg_writes     = 0;
    int settings_used  = 0;
    int quiet_cycles   = 0;

    task automatic report_fault(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        faults++;
    endtask

    // frame checks in priority order; returns the result status
    function automatic logic [3:0] judge_frame(input logic [CONC_W-1:0] conc);
        logic [7:0] want_sum;
        want_sum = ~sum_acc + 8'd1;
        if (frame_img[0] != srcd_pkg::HDR_BYTE || frame_img[FR_LAST] != srcd_pkg::TAIL_BYTE)
            return srcd_pkg::STS_FRAMING;
        if (frame_img[1] != cmd_reg) return srcd_pkg::STS_CMD;
        case (frame_img[2])
            srcd_pkg::RESP_OK: begin
            end
            srcd_pkg::RESP_EXEC:    return srcd_pkg::STS_EXEC;
            srcd_pkg::RESP_CMD_ERR: return srcd_pkg::STS_CMD;
            srcd_pkg::RESP_NO_ZERO: return srcd_pkg::STS_NO_ZERO;
            default:                return srcd_pkg::STS_BAD_RESP;
        endcase
        if (frame_img[FR_CSUM] != want_sum) return srcd_pkg::STS_CHECKSUM;
        case (frame_img[7])
            srcd_pkg::SNS_UNCAL: return srcd_pkg::STS_UNCAL;
            srcd_pkg::SNS_OK: begin
            end
            srcd_pkg::SNS_ZERO_SHIFT: return srcd_pkg::STS_ZERO_SHIFT;
            srcd_pkg::SNS_CALIB:      return srcd_pkg::STS_CALIB;
            srcd_pkg::SNS_FAULT:      return srcd_pkg::STS_FAULT;
            default:                  return srcd_pkg::STS_BAD_STATUS;
        endcase
        if (conc == srcd_pkg::CONC_BAD) return srcd_pkg::STS_BAD_VALUE;
        return srcd_pkg::STS_OK;
    endfunction

    // linear map of concentration onto the loop DAC span
    function automatic logic [CODE_W-1:0] dac_for(input logic [CONC_W-1:0] conc);
        logic [63:0] prod;
        logic [63:0] quot;
        if (range_reg == 32'd0 || conc <= zero_reg) return srcd_pkg::CODE_MIN;
        if (32'(conc) >= range_reg) return srcd_pkg::CODE_MAX;
        prod = 64'(conc) * 64'(srcd_pkg::CODE_SPAN);
        quot = prod / 64'(range_reg);
        return srcd_pkg::CODE_MIN + quot[CODE_W-1:0];
    endfunction

    // advance the checker by one accepted word; queue the reply it causes
    task automatic check_reply_word(input logic [1:0] act, input logic [7:0] rx);
        t_reply                     r;
        logic [srcd_pkg::POS_W-1:0] pos;
        logic [CONC_W-1:0]          conc;
        logic [3:0]                 sts;
        if (act == srcd_pkg::ACT_NONE) return;
        r.status = srcd_pkg::STS_NOT_READY;
        r.conc   = '0;
        r.code   = '0;
        r.upd    = 1'b0;
        r.resend = 1'b0;
        r.lost   = lost_cnt;
        if (!ready_reg) begin
            replies_due.push_back(r);
            return;
        end
        conc = '0;
        if (act == srcd_pkg::ACT_BYTE) begin
            pos = byte_pos;
            if (pos >= FR_LEN) pos = '0;
            frame_img[pos] = rx;
            if (pos < FR_CSUM) sum_acc = sum_acc + rx;
            if (pos + 1 < FR_LEN) begin
                byte_pos = pos + 1'b1;
                return;
            end
            conc = {frame_img[3], frame_img[4]};
            sts  = judge_frame(conc);
        end else begin
            sts = {2'b00, act};
        end
        byte_pos = '0;
        sum_acc  = 8'd0;
        if (sts == srcd_pkg::STS_OK) begin
            retry_cnt = 3'd0;
            lost_cnt  = 8'd0;
            r.conc    = conc;
            r.code    = dac_for(conc);
            r.upd     = 1'b1;
        end else begin
            retry_cnt = retry_cnt + 3'd1;
            if (retry_cnt < retries_reg) begin
                r.resend = 1'b1;
            end else begin
                retry_cnt = 3'd0;
                if (lost_cnt != 8'd255) lost_cnt = lost_cnt + 8'd1;
                if (lost_cnt >= lost_lim_reg) begin
                    r.code = alarm_reg;
                    r.upd  = 1'b1;
                end
            end
        end
        r.status = sts;
        r.lost   = lost_cnt;
        replies_due.push_back(r);
    endtask

    // acceptance, prediction, result checking and watchdog
    always @(posedge i_clk) begin : watch_edges
        t_reply want;
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_in_valid && !o_in_stall) begin
                check_reply_word(i_action, i_rx_byte);
                word_taken = 1'b1;
                words_accepted++;
                quiet_cycles = 0;
            end
            if (i_cfg_valid && o_cfg_ready) quiet_cycles = 0;
            if (o_out_valid && !i_out_stall) begin
                quiet_cycles = 0;
                results_seen++;
                if (replies_due.size() == 0) begin
                    report_fault($sformatf("result with nothing due, status %0d", o_status));
                end else begin
                    want = replies_due.pop_front();
                    if (o_status !== want.status)
                        report_fault($sformatf("status %0d, want %0d", o_status, want.status));
                    if (o_concentration !== want.conc)
                        report_fault($sformatf("concentration %0d, want %0d",
                                               o_concentration, want.conc));
                    if (o_dac_code !== want.code)
                        report_fault($sformatf("dac_code %0d, want %0d", o_dac_code, want.code));
                    if (o_dac_update !== want.upd)
                        report_fault($sformatf("dac_update %0b, want %0b",
                                               o_dac_update, want.upd));
                    if (o_resend !== want.resend)
                        report_fault($sformatf("resend %0b, want %0b", o_resend, want.resend));
                    if (o_lost_count !== want.lost)
                        report_fault($sformatf("lost_count %0d, want %0d",
                                               o_lost_count, want.lost));
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: nothing moved for %0d cycles, %0d results still due",
                         quiet_cycles, replies_due.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // sender in bursts with gaps; receiver stalls on its own pattern
    always @(negedge i_clk) begin : drive_words
        t_word w;
        logic  nv;
        logic  ns;
        if (i_rst_n) begin
            if (!i_in_valid || word_taken) begin
                word_taken = 1'b0;
                nv = 1'b0;
                w  = {i_action, i_rx_byte};
                if (gap_left > 0) begin
                    gap_left--;
                end else if (words_to_send.size() > 0) begin
                    w  = words_to_send.pop_front();
                    nv = 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = int'($urandom_range(1, 24));
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                 : int'($urandom_range(1, 12));
                    end
                end
                i_in_valid <= nv;
                i_action   <= w.act;
                i_rx_byte  <= w.rx;
            end
            if (stall_left == 0) begin
                stall_kind = int'($urandom_range(STALL_FREE, STALL_CHOPPY));
                stall_left = (stall_kind == STALL_HOLD) ? int'($urandom_range(1, 20))
                                                        : int'($urandom_range(1, 40));
            end
            stall_left--;
            case (stall_kind)
                STALL_FREE: ns = 1'b0;
                STALL_HOLD: ns = 1'b1;
                default:    ns = 1'($urandom_range(0, 1));
            endcase
            i_out_stall <= ns;
        end
    end

    task automatic queue_word(input logic [1:0] act, input logic [7:0] rx);
        t_word w;
        w.act = act;
        w.rx  = rx;
        words_to_send.push_back(w);
        if (act != srcd_pkg::ACT_NONE) words_queued++;
    endtask

    function automatic logic [7:0] other_than(input logic [7:0] x);
        logic [7:0] v;
        v = 8'($urandom);
        if (v == x) v = ~x;
        return v;
    endfunction

    function automatic logic [1:0] pick_event();
        return ($urandom_range(0, 1) != 0) ? srcd_pkg::ACT_TIMEOUT : srcd_pkg::ACT_FAULT;
    endfunction

    function automatic logic [CONC_W-1:0] pick_conc();
        logic in_range;
        in_range = (range_reg != 32'd0 && range_reg <= 32'd65535);
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFE;
            2: return zero_reg;
            3: return zero_reg + 16'd1;
            4: return in_range ? range_reg[15:0] - 16'd1 : 16'($urandom);
            5: return in_range ? range_reg[15:0] : 16'($urandom);
            default: return in_range ? 16'($urandom_range(0, range_reg)) : 16'($urandom);
        endcase
    endfunction

    // one reply of the given kind, with ignored words scattered in
    task automatic send_frame(input int kind, input logic [CONC_W-1:0] conc);
        logic [7:0] fb [FR_LEN];
        logic [7:0] s;
        int         cut;
        if ($urandom_range(0, 11) == 0) queue_word(srcd_pkg::ACT_NONE, 8'($urandom));
        if (kind == FR_NOISE) begin
            repeat ($urandom_range(1, FR_LAST)) queue_word(srcd_pkg::ACT_BYTE, 8'($urandom));
            queue_word(pick_event(), 8'($urandom));
            return;
        end
        fb[0] = srcd_pkg::HDR_BYTE;
        fb[1] = cmd_reg;
        fb[2] = srcd_pkg::RESP_OK;
        fb[3] = conc[15:8];
        fb[4] = conc[7:0];
        fb[5] = 8'($urandom);
        fb[6] = 8'($urandom);
        fb[7] = srcd_pkg::SNS_OK;
        fb[FR_LAST] = srcd_pkg::TAIL_BYTE;
        case (kind)
            FR_BAD_HDR:      fb[0] = other_than(srcd_pkg::HDR_BYTE);
            FR_BAD_TAIL:     fb[FR_LAST] = other_than(srcd_pkg::TAIL_BYTE);
            FR_BAD_CMD:      fb[1] = other_than(cmd_reg);
            FR_RESP_EXEC:    fb[2] = srcd_pkg::RESP_EXEC;
            FR_RESP_CMD_ERR: fb[2] = srcd_pkg::RESP_CMD_ERR;
            FR_RESP_NO_ZERO: fb[2] = srcd_pkg::RESP_NO_ZERO;
            FR_RESP_OTHER:   fb[2] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(5, 255));
            FR_SNS_UNCAL:    fb[7] = srcd_pkg::SNS_UNCAL;
            FR_SNS_SHIFT:    fb[7] = srcd_pkg::SNS_ZERO_SHIFT;
            FR_SNS_CALIB:    fb[7] = srcd_pkg::SNS_CALIB;
            FR_SNS_FAULT:    fb[7] = srcd_pkg::SNS_FAULT;
            FR_SNS_OTHER:    fb[7] = 8'($urandom_range(5, 255));
            FR_BAD_VALUE: begin
                fb[3] = 8'hFF;
                fb[4] = 8'hFF;
            end
            default: begin
            end
        endcase
        s = 8'd0;
        for (int i = 0; i < FR_CSUM; i++) s = s + fb[i];
        fb[FR_CSUM] = 8'd0 - s;
        if (kind == FR_BAD_SUM) fb[FR_CSUM] = fb[FR_CSUM] ^ 8'($urandom_range(1, 255));
        cut = FR_LEN;
        if (kind == FR_CUT_TIMEOUT || kind == FR_CUT_FAULT)
            cut = int'($urandom_range(1, FR_LAST));
        if (kind == FR_TIMEOUT || kind == FR_FAULT) cut = 0;
        for (int i = 0; i < cut; i++) begin
            if ($urandom_range(0, 40) == 0) queue_word(srcd_pkg::ACT_NONE, 8'($urandom));
            queue_word(srcd_pkg::ACT_BYTE, fb[i]);
        end
        if (cut < FR_LEN)
            queue_word((kind == FR_CUT_FAULT || kind == FR_FAULT) ? srcd_pkg::ACT_FAULT
                                                                  : srcd_pkg::ACT_TIMEOUT,
                       8'($urandom));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            srcd_pkg::REG_RANGE:    range_reg    = val;
            srcd_pkg::REG_ZERO:     zero_reg     = val[15:0];
            srcd_pkg::REG_COMMAND:  cmd_reg      = val[7:0];
            srcd_pkg::REG_RETRIES:  retries_reg  = val[2:0];
            srcd_pkg::REG_LOST_LIM: lost_lim_reg = val[7:0];
            srcd_pkg::REG_ALARM:    alarm_reg    = val[CODE_W-1:0];
            srcd_pkg::REG_READY:    ready_reg    = val[0];
            default: begin
            end
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [31:0] range_v, input logic [15:0] zero_v,
                                  input logic [7:0] cmd_v, input logic [2:0] retries_v,
                                  input logic [7:0] lost_v, input logic [11:0] alarm_v,
                                  input logic ready_v);
        write_reg(srcd_pkg::REG_RANGE, range_v);
        write_reg(srcd_pkg::REG_ZERO, {16'd0, zero_v});
        write_reg(srcd_pkg::REG_COMMAND, {24'd0, cmd_v});
        write_reg(srcd_pkg::REG_RETRIES, {29'd0, retries_v});
        write_reg(srcd_pkg::REG_LOST_LIM, {24'd0, lost_v});
        write_reg(srcd_pkg::REG_ALARM, {20'd0, alarm_v});
        write_reg(srcd_pkg::REG_READY, {31'd0, ready_v});
        settings_used++;
    endtask

    // wait for every word to go in and every reply to come out, then let it settle
    task automatic wait_idle();
        while (words_to_send.size() != 0 || i_in_valid || replies_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_frames(input int n_words, input int good_pct);
        int target;
        target = words_queued + n_words;
        while (words_queued < target) begin
            if ($urandom_range(0, 99) < good_pct) send_frame(FR_GOOD, pick_conc());
            else send_frame(int'($urandom_range(FR_BAD_HDR, FR_NOISE)), pick_conc());
        end
        wait_idle();
    endtask

    initial begin : stimulus
        logic [31:0] r;
        for (int i = 0; i < FR_LEN; i++) frame_img[i] = 8'h00;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // out of reset the sensor is not ready: every word is refused
        queue_word(srcd_pkg::ACT_BYTE, 8'h00);
        queue_word(srcd_pkg::ACT_BYTE, 8'hFF);
        queue_word(srcd_pkg::ACT_TIMEOUT, 8'h00);
        queue_word(srcd_pkg::ACT_FAULT, 8'hFF);
        queue_word(srcd_pkg::ACT_NONE, 8'h5A);
        wait_idle();

        // directed: good frame, failures up to the alarm, a cut frame
        apply_settings(32'd1000, 16'd100, 8'h03, 3'd2, 8'd2, 12'hABC, 1'b1);
        send_frame(FR_GOOD, 16'd500);
        queue_word(srcd_pkg::ACT_TIMEOUT, 8'h00);
        queue_word(srcd_pkg::ACT_FAULT, 8'h00);
        queue_word(srcd_pkg::ACT_TIMEOUT, 8'hFF);
        queue_word(srcd_pkg::ACT_FAULT, 8'hFF);
        queue_word(srcd_pkg::ACT_NONE, 8'h00);
        queue_word(srcd_pkg::ACT_BYTE, srcd_pkg::HDR_BYTE);
        queue_word(srcd_pkg::ACT_BYTE, 8'h03);
        queue_word(srcd_pkg::ACT_BYTE, srcd_pkg::RESP_OK);
        queue_word(srcd_pkg::ACT_TIMEOUT, 8'h00);
        wait_idle();

        // widest range, all-ones command, slowest loss
        apply_settings(32'hFFFF_FFFF, 16'd0, 8'hFF, 3'd7, 8'd255, 12'd0, 1'b1);
        run_frames(200, 50);

        // zero range, top zero point, fastest loss
        apply_settings(32'd0, 16'hFFFF, 8'h00, 3'd1, 8'd1, 12'hFFF, 1'b1);
        run_frames(150, 40);

        // zero retries and zero lost limit; a long failure run saturates the counter
        apply_settings(32'd1, 16'd0, 8'h55, 3'd0, 8'd0, 12'($urandom), 1'b1);
        repeat (270) queue_word(pick_event(), 8'($urandom));
        wait_idle();
        run_frames(60, 60);

        // sensor not ready again: words are refused and leave the state alone
        apply_settings(32'd50000, 16'd20, 8'h03, 3'd3, 8'd3, 12'd4095, 1'b0);
        run_frames(40, 50);

        // random settings with the range from 1 to 70000, which may lie past the concentration span
        repeat (2) begin
            r = $urandom_range(1, 70000);
            apply_settings(r, 16'($urandom_range(0, r / 2)), 8'($urandom),
                           3'($urandom_range(0, 7)), 8'($urandom_range(0, 6)),
                           12'($urandom_range(0, 4095)), 1'b1);
            run_frames(180, 55);
        end

        if (replies_due.size() != 0)
            report_fault($sformatf("%0d replies never arrived", replies_due.size()));
        $display("tb: %0d words accepted, %0d results checked, %0d register writes",
                 words_accepted, results_seen, reg_writes);
        $display("tb: %0d register settings, %0d mismatches", settings_used, faults);
        if (faults == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
